### design/ffba_pkg.sv
// ffba_pkg: shared types, sizes and codes for the first-fit block allocator.
// No dependencies; used by every module of the allocator but ffba_ram.
`default_nettype none

package ffba_pkg;

   // map size and derived widths
   localparam int UNITS  = 1024;
   localparam int MAP_AW = $clog2(UNITS);
   localparam int MAP_CW = $clog2(UNITS + 1);
   localparam int BASE_W = 10;
   localparam int LEN_W  = 11;
   localparam int PTR_W  = (MAP_CW > BASE_W) ? MAP_CW : BASE_W;
   localparam int CMP_W  = (MAP_CW > LEN_W) ? MAP_CW : LEN_W;

   // request codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [BASE_W-1:0] base_in;
      logic [LEN_W-1:0]  length;
   } ffba_req_type;

   typedef struct packed {
      logic              granted;
      logic [BASE_W-1:0] base_out;
   } ffba_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_FREE,
      ST_DONE
   } ffba_state_type;

   // controller -> datapath
   typedef struct packed {
      logic clr_step;
      logic load;
      logic scan_step;
      logic mark_load;
      logic mark_step;
      logic free_step;
      logic rsp_load;
   } ffba_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ptr_last;
      logic is_free;
      logic size_bad;
      logic hit;
      logic scan_end;
      logic cnt_zero;
      logic free_done;
      logic rsp_free;
   } ffba_stat_type;

endpackage

`default_nettype wire

### design/first_fit_block_allocator.sv
// first_fit_block_allocator: top level of the first-fit bitmap allocator.
// Depends on ffba_pkg, ffba_ctrl, ffba_dp (which holds ffba_ram).
//
//   channel | ports                            | word
//   --------+----------------------------------+---------------------------------
//   request | req_valid, req_stall, req_data   | req_type, base_in, length
//   result  | rsp_valid, rsp_stall, rsp_data   | granted, base_out
//
// One request at a time. Allocate: serial map scan (one map bit per cycle
// through the RAM read port), then marking of length bits through the write
// port. Free: a dispatch step, then clearing of min(length, UNITS-base_in)
// bits through the write port. Each request also passes capture and result hand-off.
// After reset the map is cleared one bit a cycle, all UNITS bits, with
// req_stall high. A finished result waits in its register while the next
// request is taken; the block only holds in its last state if that
// register is still full and stalled.
`default_nettype none

module first_fit_block_allocator (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire ffba_pkg::ffba_req_type req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      ffba_pkg::ffba_rsp_type rsp_data
);

   ffba_pkg::ffba_cmd_type  cmd;
   ffba_pkg::ffba_stat_type stat;

   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffba_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### design/ffba_ram.sv
// ffba_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/ffba_dp.sv
// ffba_dp: allocator datapath - request capture, map pointer, run tracking,
// result register and the used-map RAM. Depends on ffba_pkg and ffba_ram.
`default_nettype none

module ffba_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ffba_pkg::ffba_cmd_type cmd,
   output      ffba_pkg::ffba_stat_type stat,
   input  wire ffba_pkg::ffba_req_type req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      ffba_pkg::ffba_rsp_type rsp_data
);

   ffba_pkg::ffba_req_type         req_ff, req_in;
   logic [ffba_pkg::PTR_W-1:0]     ptr_ff, ptr_in;
   logic [ffba_pkg::PTR_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [ffba_pkg::PTR_W-1:0]     start_ff, start_in;
   logic [ffba_pkg::CMP_W-1:0]     run_ff, run_in;
   logic [ffba_pkg::LEN_W-1:0]     cnt_ff, cnt_in;
   logic                           pend_ff, pend_in;
   logic                           ok_ff, ok_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ffba_pkg::ffba_rsp_type         rsp_ff, rsp_in;

   logic                           ptr_ge;
   logic [ffba_pkg::PTR_W-1:0]     hit_start;
   logic [ffba_pkg::CMP_W-1:0]     len_ext;
   logic                           map_bit;
   logic                           wr_en;
   logic                           rd_en;

   assign ptr_ge    = (ptr_ff >= ffba_pkg::PTR_W'(ffba_pkg::UNITS));
   assign len_ext   = ffba_pkg::CMP_W'(req_ff.length);
   assign hit_start = (run_ff == '0) ? rd_addr_ff : start_ff;

   always_comb begin
      stat.ptr_last  = (ptr_ff == ffba_pkg::PTR_W'(ffba_pkg::UNITS - 1));
      stat.is_free   = (req_ff.req_type == ffba_pkg::OP_FREE);
      stat.size_bad  = (req_ff.length == '0)
                       || (len_ext > ffba_pkg::CMP_W'(ffba_pkg::UNITS));
      stat.hit       = pend_ff && !map_bit && ((run_ff + 1'b1) == len_ext);
      stat.scan_end  = !pend_ff && ptr_ge;
      stat.cnt_zero  = (cnt_ff == '0);
      stat.free_done = (cnt_ff == '0) || ptr_ge;
      stat.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   // map write port: clearing pass, marking and freeing share it
   assign wr_en = cmd.clr_step || cmd.mark_step || (cmd.free_step && !stat.free_done);
   assign rd_en = cmd.scan_step && !ptr_ge;

   always_comb begin
      req_in       = req_ff;
      ptr_in       = ptr_ff;
      rd_addr_in   = rd_addr_ff;
      start_in     = start_ff;
      run_in       = run_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      ok_in        = ok_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.clr_step) begin
         ptr_in = ptr_ff + 1'b1;
      end

      if (cmd.load) begin
         req_in  = req_data;
         run_in  = '0;
         pend_in = 1'b0;
         cnt_in  = req_data.length;
         ok_in   = (req_data.req_type == ffba_pkg::OP_FREE);
         if (req_data.req_type == ffba_pkg::OP_FREE) begin
            ptr_in = ffba_pkg::PTR_W'(req_data.base_in);
         end else begin
            ptr_in = '0;
         end
      end

      if (cmd.scan_step) begin
         // read data arriving now belongs to rd_addr_ff
         pend_in    = !ptr_ge;
         rd_addr_in = ptr_ff;
         if (!ptr_ge) begin
            ptr_in = ptr_ff + 1'b1;
         end
         if (pend_ff) begin
            if (!map_bit) begin
               run_in   = run_ff + 1'b1;
               start_in = hit_start;
            end else begin
               run_in = '0;
            end
         end
      end

      if (cmd.mark_load) begin
         ptr_in   = hit_start;
         start_in = hit_start;
         cnt_in   = req_ff.length;
         ok_in    = 1'b1;
      end

      if (cmd.mark_step || (cmd.free_step && !stat.free_done)) begin
         ptr_in = ptr_ff + 1'b1;
         cnt_in = cnt_ff - 1'b1;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in    = 1'b1;
         rsp_in.granted  = ok_ff;
         if (!ok_ff) begin
            rsp_in.base_out = '0;
         end else if (req_ff.req_type == ffba_pkg::OP_FREE) begin
            rsp_in.base_out = req_ff.base_in;
         end else begin
            rsp_in.base_out = start_ff[ffba_pkg::BASE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rd_addr_ff <= rd_addr_in;
      start_ff   <= start_in;
      run_ff     <= run_in;
      cnt_ff     <= cnt_in;
      ok_ff      <= ok_in;
      rsp_ff     <= rsp_in;
   end

   ffba_ram #(
      .WIDTH (1),
      .DEPTH (ffba_pkg::UNITS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ptr_ff[ffba_pkg::MAP_AW-1:0]),
      .wr_data (cmd.mark_step),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff[ffba_pkg::MAP_AW-1:0]),
      .rd_data (map_bit)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### design/ffba_ctrl.sv
// ffba_ctrl: allocator controller - clearing pass, scan, mark, free and
// result hand-off sequencing. Depends on ffba_pkg.
`default_nettype none

module ffba_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire ffba_pkg::ffba_stat_type stat,
   output      ffba_pkg::ffba_cmd_type  cmd
);

   ffba_pkg::ffba_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffba_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ffba_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.ptr_last) begin
               state_in = ffba_pkg::ST_IDLE;
            end
         end
         ffba_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ffba_pkg::ST_SCAN;
            end
         end
         ffba_pkg::ST_SCAN: begin
            if (stat.is_free) begin
               state_in = ffba_pkg::ST_FREE;
            end else if (stat.size_bad) begin
               state_in = ffba_pkg::ST_DONE;
            end else if (stat.hit) begin
               cmd.mark_load = 1'b1;
               state_in      = ffba_pkg::ST_MARK;
            end else if (stat.scan_end) begin
               state_in = ffba_pkg::ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ffba_pkg::ST_MARK: begin
            if (stat.cnt_zero) begin
               state_in = ffba_pkg::ST_DONE;
            end else begin
               cmd.mark_step = 1'b1;
            end
         end
         ffba_pkg::ST_FREE: begin
            if (stat.free_done) begin
               state_in = ffba_pkg::ST_DONE;
            end else begin
               cmd.free_step = 1'b1;
            end
         end
         ffba_pkg::ST_DONE: begin
            // wait for the result register to open up
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ffba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffba_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
